[rtl/fsbf_pkg.sv]
// Shared types, constants and codes of the fair-share batch FIFO.
`timescale 1ns / 1ps
package fsbf_pkg;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned MAX_TAKE    = 64;
  localparam int unsigned HANDLE_BITS = 16;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TAKE_W = $clog2(MAX_TAKE + 1);
  localparam int unsigned CMP_W  = (CNT_W > TAKE_W) ? CNT_W : TAKE_W;
  localparam int unsigned DIVC_W = $clog2(CNT_W + 1);

  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned CONS_W  = 8;
  localparam int unsigned OCC_W   = 11;

  typedef enum logic [1:0] {
    STAT_POPPED   = 2'd0,
    STAT_APPENDED = 2'd1,
    STAT_DROPPED  = 2'd2,
    STAT_NONE     = 2'd3
  } status_e;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef struct packed {
    action_e                action;
    logic [HANDLE_BITS-1:0] handle;
    logic                   batch_end;
    logic [LIMIT_W-1:0]     take_limit;
    logic [CONS_W-1:0]      consumers;
  } req_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] out_handle;
    status_e                status;
    logic                   last;
    logic [OCC_W-1:0]       occupancy;
  } rsp_t;

endpackage

[rtl/fsbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fsbf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/fsbf_div.sv]
// Restoring divider that forms one quotient bit of the queue count per cycle.
`timescale 1ns / 1ps
module fsbf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fsbf_pkg::CNT_W-1:0]  dividend_i,
  input  logic [fsbf_pkg::CONS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [fsbf_pkg::CNT_W-1:0]  quotient_o
);

  import fsbf_pkg::*;

  logic [CNT_W-1:0]  dvd_q, dvd_d;
  logic [CONS_W-1:0] rem_q, rem_d;
  logic [CONS_W-1:0] dsr_q, dsr_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic              run_q, run_d;
  logic [CONS_W:0]   shifted;
  logic [CONS_W-1:0] diff;

  always_comb begin
    shifted = {rem_q, dvd_q[CNT_W-1]};
    diff    = shifted[CONS_W-1:0] - dsr_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = DIVC_W'(CNT_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (shifted >= {1'b0, dsr_q}) begin
          rem_d = diff;
          dvd_d = {dvd_q[CNT_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[CONS_W-1:0];
          dvd_d = {dvd_q[CNT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = run_q && (cnt_q == '0);
  assign quotient_o = dvd_q;

endmodule

[rtl/fair_share_batch_fifo_unit.sv]
// Top level of the fair-share batch FIFO: ring store, pointers and pop sequencer.
`timescale 1ns / 1ps
// A push leaves busy low, and the last push of a batch shows its result on the cycle
// after the transfer. A pop first divides the queue count by the number of consumers
// in a bit-serial divider (one quotient bit per cycle, eleven bits for the default
// depth), then reads one handle per cycle from the single read port of the store,
// holding busy meanwhile; a pop that takes nothing answers on the next cycle.
// Every result is presented for exactly one cycle with result_valid_o and must be
// taken then; there is no way to hold results back.
module fair_share_batch_fifo_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  fsbf_pkg::req_t  req_i,
  output logic            result_valid_o,
  output fsbf_pkg::rsp_t  rsp_o
);

  import fsbf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_POP  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [CNT_W-1:0]  queued_q, queued_d;
  logic              dropped_q, dropped_d;
  logic [TAKE_W-1:0] lim_q, lim_d;
  logic [TAKE_W-1:0] remain_q, remain_d;
  logic              rd_pend_q, rd_pend_d;
  logic              rd_last_q, rd_last_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic                   accept;
  logic                   full;
  logic                   ram_we;
  logic                   ram_re;
  logic [HANDLE_BITS-1:0] ram_rdata;
  logic                   div_start;
  logic                   div_done;
  logic [CNT_W-1:0]       quot;
  logic [CMP_W-1:0]       share;
  logic [CMP_W-1:0]       take_c;

  assign busy   = (state_q != ST_IDLE) || rd_pend_q;
  assign accept = start && !busy;
  assign full   = (queued_q == CNT_W'(QUEUE_DEPTH));

  fsbf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (queued_q),
    .divisor_i  (req_i.consumers),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  fsbf_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (req_i.handle),
    .re_i    (ram_re),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    share  = (quot < queued_q) ? CMP_W'(quot) + 1'b1 : CMP_W'(quot);
    take_c = (share > CMP_W'(lim_q)) ? CMP_W'(lim_q) : share;
  end

  always_comb begin
    state_d     = state_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    queued_d    = queued_q;
    dropped_d   = dropped_q;
    lim_d       = lim_q;
    remain_d    = remain_q;
    rd_pend_d   = 1'b0;
    rd_last_d   = 1'b0;
    out_valid_d = 1'b0;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_PUSH) begin
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              ram_we   = 1'b1;
              wptr_d   = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
              queued_d = queued_q + 1'b1;
            end
            if (req_i.batch_end) begin
              out_valid_d     = 1'b1;
              out_d.out_handle = '0;
              out_d.status    = (dropped_q || full) ? STAT_DROPPED : STAT_APPENDED;
              out_d.last      = 1'b1;
              out_d.occupancy = OCC_W'(queued_d);
              dropped_d       = 1'b0;
            end
          end else if ((req_i.take_limit == '0) || (req_i.consumers == '0) ||
                       (queued_q == '0)) begin
            out_valid_d      = 1'b1;
            out_d.out_handle = '0;
            out_d.status     = STAT_NONE;
            out_d.last       = 1'b1;
            out_d.occupancy  = OCC_W'(queued_q);
          end else begin
            div_start = 1'b1;
            lim_d     = (req_i.take_limit > LIMIT_W'(MAX_TAKE)) ? TAKE_W'(MAX_TAKE)
                                                               : TAKE_W'(req_i.take_limit);
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          remain_d = TAKE_W'(take_c);
          queued_d = queued_q - CNT_W'(take_c);
          state_d  = ST_POP;
        end
      end
      ST_POP: begin
        ram_re    = 1'b1;
        rptr_d    = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
        remain_d  = remain_q - 1'b1;
        rd_pend_d = 1'b1;
        rd_last_d = (remain_q == TAKE_W'(1));
        if (remain_q == TAKE_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rd_pend_q) begin
      out_valid_d      = 1'b1;
      out_d.out_handle = ram_rdata;
      out_d.status     = STAT_POPPED;
      out_d.last       = rd_last_q;
      out_d.occupancy  = OCC_W'(queued_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rptr_q      <= '0;
      wptr_q      <= '0;
      queued_q    <= '0;
      dropped_q   <= 1'b0;
      remain_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      queued_q    <= queued_d;
      dropped_q   <= dropped_d;
      remain_q    <= remain_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    if (out_valid_d) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign rsp_o          = out_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_q <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds the store depth.");

  a_read_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == ST_POP))
    else $error("Store read data arrived without a pop read.");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("Divider finished outside the divide phase.");

  a_nonpop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != STAT_POPPED)) |-> rsp_o.last)
    else $error("Push or empty-pop result without the last mark.");

  a_pop_take_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> (remain_q != '0))
    else $error("Pop phase entered with nothing to take.");
`endif

endmodule

[tb/fair_share_batch_fifo_unit_tb.sv]
// Self-checking regression of the fair-share batch FIFO with its own queue predictor.
`timescale 1ns / 1ps
module fair_share_batch_fifo_unit_tb;
  import fsbf_pkg::*;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  result_valid_o;
  rsp_t  rsp_o;

  logic [HANDLE_BITS-1:0] model_handles[$];
  logic                   model_dropped;
  rsp_t                   pending_rsp[$];
  rsp_t                   expected_rsp;
  int unsigned            mismatches;
  int unsigned            idle_pct;

  fair_share_batch_fifo_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("fair_share_batch_fifo_unit regression: fail");
    $finish;
  end

  function automatic void predict_step(input req_t item);
    rsp_t        r;
    int unsigned q;
    int unsigned take;
    int unsigned lim;
    r = '0;
    if (item.action == ACT_PUSH) begin
      if (model_handles.size() >= QUEUE_DEPTH) begin
        model_dropped = 1'b1;
      end else begin
        model_handles.push_back(item.handle);
      end
      if (item.batch_end) begin
        r.status    = model_dropped ? STAT_DROPPED : STAT_APPENDED;
        r.last      = 1'b1;
        r.occupancy = OCC_W'(model_handles.size());
        pending_rsp.push_back(r);
        model_dropped = 1'b0;
      end
    end else begin
      q   = model_handles.size();
      lim = item.take_limit;
      if (lim == 0 || item.consumers == 0 || q == 0) begin
        r.status    = STAT_NONE;
        r.last      = 1'b1;
        r.occupancy = OCC_W'(q);
        pending_rsp.push_back(r);
      end else begin
        if (lim > MAX_TAKE) lim = MAX_TAKE;
        take = q / item.consumers;
        if (take < q) take++;
        if (take > lim) take = lim;
        for (int unsigned i = 0; i < take; i++) begin
          r.out_handle = model_handles.pop_front();
          r.status     = STAT_POPPED;
          r.last       = (i == take - 1);
          r.occupancy  = OCC_W'(q - take);
          pending_rsp.push_back(r);
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_step(req_i);
      if (result_valid_o) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected result: out_handle %0h status %0d last %0d occupancy %0d",
                 rsp_o.out_handle, rsp_o.status, rsp_o.last, rsp_o.occupancy);
          mismatches++;
        end else begin
          expected_rsp = pending_rsp.pop_front();
          if (rsp_o.out_handle !== expected_rsp.out_handle) begin
            $error("out_handle: expected %0h, actual %0h",
                   expected_rsp.out_handle, rsp_o.out_handle);
            mismatches++;
          end
          if (rsp_o.status !== expected_rsp.status) begin
            $error("status: expected %0d, actual %0d", expected_rsp.status, rsp_o.status);
            mismatches++;
          end
          if (rsp_o.last !== expected_rsp.last) begin
            $error("last: expected %0d, actual %0d", expected_rsp.last, rsp_o.last);
            mismatches++;
          end
          if (rsp_o.occupancy !== expected_rsp.occupancy) begin
            $error("occupancy: expected %0d, actual %0d",
                   expected_rsp.occupancy, rsp_o.occupancy);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic req_t push_req(input logic [HANDLE_BITS-1:0] h, input logic bend);
    req_t r;
    r.action     = ACT_PUSH;
    r.handle     = h;
    r.batch_end  = bend;
    r.take_limit = LIMIT_W'($urandom);
    r.consumers  = CONS_W'($urandom);
    return r;
  endfunction

  function automatic req_t pop_req(input logic [LIMIT_W-1:0] lim,
                                   input logic [CONS_W-1:0] cons);
    req_t r;
    r.action     = ACT_POP;
    r.handle     = HANDLE_BITS'($urandom);
    r.batch_end  = 1'($urandom_range(1));
    r.take_limit = lim;
    r.consumers  = cons;
    return r;
  endfunction

  function automatic req_t rand_pop_req();
    int unsigned    sel;
    logic [LIMIT_W-1:0] lim;
    logic [CONS_W-1:0]  cons;
    sel = $urandom_range(99);
    if (sel < 5) lim = '0;
    else if (sel < 15) lim = LIMIT_W'($urandom_range(127, MAX_TAKE + 1));
    else lim = LIMIT_W'($urandom_range(MAX_TAKE, 1));
    sel = $urandom_range(99);
    if (sel < 5) cons = '0;
    else if (sel < 20) cons = CONS_W'($urandom_range(255, 9));
    else cons = CONS_W'($urandom_range(8, 1));
    return pop_req(lim, cons);
  endfunction

  task automatic send_item(input req_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0 || busy) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_item(pop_req(7'd64, 8'd1));
    send_item(push_req(16'h0000, 1'b0));
    send_item(push_req(16'hFFFF, 1'b0));
    send_item(pop_req(7'd1, 8'd1));
    send_item(push_req(16'hA5A5, 1'b1));
    send_item(pop_req(7'd0, 8'd5));
    send_item(pop_req(7'd64, 8'd0));
    send_item(push_req(16'h5A5A, 1'b0));
    send_item(push_req(16'h1234, 1'b0));
    send_item(push_req(16'h8001, 1'b0));
    send_item(push_req(16'h7FFE, 1'b1));
    send_item(pop_req(7'd127, 8'd255));
    send_item(pop_req(7'd2, 8'd1));
    send_item(pop_req(7'd64, 8'd2));
    send_item(pop_req(7'd127, 8'd1));
    send_item(pop_req(7'd127, 8'd1));
    send_item(push_req(16'h8000, 1'b1));
    wait_drained();
  endtask

  task automatic test_overflow();
    int room;
    idle_pct = 0;
    wait_drained();
    room = QUEUE_DEPTH - model_handles.size();
    for (int k = 0; k < room; k++) begin
      send_item(push_req(HANDLE_BITS'($urandom), k == room - 1));
    end
    send_item(push_req(16'h1111, 1'b0));
    send_item(push_req(16'h2222, 1'b1));
    send_item(push_req(16'h3333, 1'b1));
    for (int k = 0; k < QUEUE_DEPTH / MAX_TAKE; k++) begin
      send_item(pop_req(7'd64, 8'd1));
    end
    send_item(push_req(16'h4444, 1'b1));
    send_item(pop_req(7'd1, 8'd1));
    wait_drained();
  endtask

  task automatic test_random(input int unsigned pct, input int unsigned count);
    int unsigned done;
    int unsigned sel;
    int unsigned len;
    idle_pct = pct;
    done     = 0;
    while (done < count) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        len = $urandom_range(6, 1);
        for (int unsigned k = 0; k < len; k++) begin
          if (k > 0 && $urandom_range(99) < 8) begin
            send_item(rand_pop_req());
            done++;
          end
          send_item(push_req(HANDLE_BITS'($urandom), k == len - 1));
        end
        done += len;
      end else if (sel < 92) begin
        send_item(rand_pop_req());
        done++;
      end else begin
        send_item(push_req(HANDLE_BITS'($urandom), 1'b0));
        done++;
      end
    end
    wait_drained();
  endtask

  initial begin
    mismatches    = 0;
    idle_pct      = 0;
    model_dropped = 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(0, 55);
    test_random(64, 55);
    test_random(20, 55);
    if (pending_rsp.size() != 0) begin
      $error("%0d expected results never arrived", pending_rsp.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("fair_share_batch_fifo_unit regression: pass");
    end else begin
      $display("fair_share_batch_fifo_unit regression: fail");
    end
    $finish;
  end

endmodule
